// ===== rtl/mbq_pkg.sv =====
`default_nettype none

package mbq_pkg;

  localparam int TICK_W  = 32;
  localparam int BTN_W   = 3;
  localparam int DELAY_W = 10;

  // Button set bit positions.
  localparam logic [BTN_W-1:0] BTN_LEFT   = 3'b001;
  localparam logic [BTN_W-1:0] BTN_RIGHT  = 3'b010;
  localparam logic [BTN_W-1:0] BTN_MIDDLE = 3'b100;

  typedef struct packed {
    logic [TICK_W-1:0] tick_count;
    logic              left_pin_n;
    logic              right_pin_n;
    logic              middle_pin_n;
    logic              macro_pin_n;
    logic              wheel_moved;
  } mbq_item_t;

  typedef struct packed {
    logic [BTN_W-1:0] reported_buttons;
    logic             macro_active;
    logic             wheel_consumed;
  } mbq_result_t;

endpackage

`default_nettype wire

// ===== rtl/mbq_if.sv =====
`default_nettype none

interface mbq_in_if import mbq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] tick_count;
  logic              left_pin_n;
  logic              right_pin_n;
  logic              middle_pin_n;
  logic              macro_pin_n;
  logic              wheel_moved;

  modport source (
    output valid, tick_count, left_pin_n, right_pin_n, middle_pin_n, macro_pin_n,
           wheel_moved,
    input  ready
  );
  modport sink (
    input  valid, tick_count, left_pin_n, right_pin_n, middle_pin_n, macro_pin_n,
           wheel_moved,
    output ready
  );
endinterface

interface mbq_out_if import mbq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] reported_buttons;
  logic             macro_active;
  logic             wheel_consumed;

  modport source (
    output valid, reported_buttons, macro_active, wheel_consumed,
    input  ready
  );
  modport sink (
    input  valid, reported_buttons, macro_active, wheel_consumed,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/mbq_cfg.sv =====
`default_nettype none

// Holds the button hold-off threshold in cycles. It is computed once when the
// delay is written, so the per-poll path only compares against a register.
module mbq_cfg import mbq_pkg::*; #(
  parameter int unsigned CLOCK_HZ = 100000000
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [DELAY_W-1:0] cfg_wdata,
  output logic      [TICK_W-1:0]  threshold
);

  localparam logic [TICK_W-1:0] SHORT_LOCKOUT = TICK_W'(CLOCK_HZ / 2000);
  localparam logic [TICK_W-1:0] CYCLES_PER_MS = TICK_W'(CLOCK_HZ / 1000);

  // The threshold wraps at 32 bits, so only the low half of the product is kept.
  logic [TICK_W-1:0] ms_cycles;
  logic [TICK_W-1:0] threshold_r;
  logic [TICK_W-1:0] threshold_nxt;

  assign ms_cycles     = {{(TICK_W-DELAY_W){1'b0}}, cfg_wdata} * CYCLES_PER_MS;
  assign threshold_nxt = ms_cycles + SHORT_LOCKOUT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= SHORT_LOCKOUT;
    end else if (cfg_we) begin
      threshold_r <= threshold_nxt;
    end
  end

  assign threshold = threshold_r;

endmodule

`default_nettype wire

// ===== rtl/mbq_core.sv =====
`default_nettype none

// Button state and lockout logic. One item is evaluated per step; the state
// registers move only when step is high.
module mbq_core import mbq_pkg::*; #(
  parameter int unsigned CLOCK_HZ = 100000000
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire mbq_item_t         item,
  input  wire logic [TICK_W-1:0] threshold,
  output mbq_result_t            result
);

  localparam logic [TICK_W-1:0] MACRO_LOCKOUT = TICK_W'(CLOCK_HZ / 5);
  localparam logic [TICK_W-1:0] SHORT_LOCKOUT = TICK_W'(CLOCK_HZ / 2000);

  logic [TICK_W-1:0] last_event_r, last_event_nxt;
  logic              macro_r, macro_nxt;
  logic              wheel_right_r, wheel_right_nxt;
  logic [BTN_W-1:0]  acc_r, acc_nxt;

  logic [TICK_W-1:0] elapsed;
  logic              macro_tog;
  logic              mid_tog;
  logic              accept;
  logic              consumed;
  logic [BTN_W-1:0]  buttons;

  assign elapsed = item.tick_count - last_event_r;

  // A toggle stamps the event time, which makes the elapsed time zero for the
  // checks that follow in the same poll, so those are simply blocked.
  assign macro_tog       = !item.macro_pin_n && (elapsed > MACRO_LOCKOUT);
  assign macro_nxt       = macro_r ^ macro_tog;
  assign mid_tog         = macro_nxt && !macro_tog && !item.middle_pin_n &&
                           (elapsed > SHORT_LOCKOUT);
  assign wheel_right_nxt = wheel_right_r ^ mid_tog;
  assign consumed        = macro_nxt && item.wheel_moved;

  always_comb begin
    buttons = '0;
    if (!item.left_pin_n) begin
      buttons = buttons | BTN_LEFT;
    end
    if (!item.right_pin_n) begin
      buttons = buttons | BTN_RIGHT;
    end
    if (macro_nxt) begin
      if (item.wheel_moved) begin
        buttons = buttons | (wheel_right_nxt ? BTN_RIGHT : BTN_LEFT);
      end
    end else if (!item.middle_pin_n) begin
      buttons = buttons | BTN_MIDDLE;
    end
  end

  assign accept = (buttons != acc_r) && !macro_tog && !mid_tog && (elapsed > threshold);
  assign acc_nxt = accept ? buttons : acc_r;
  assign last_event_nxt = (macro_tog || mid_tog || accept) ? item.tick_count : last_event_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_event_r  <= '0;
      macro_r       <= 1'b0;
      wheel_right_r <= 1'b0;
      acc_r         <= '0;
    end else if (step) begin
      last_event_r  <= last_event_nxt;
      macro_r       <= macro_nxt;
      wheel_right_r <= wheel_right_nxt;
      acc_r         <= acc_nxt;
    end
  end

  assign result.reported_buttons = acc_nxt;
  assign result.macro_active     = macro_nxt;
  assign result.wheel_consumed   = consumed;

  a_consume_needs_macro: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.wheel_consumed |-> result.macro_active)
    else $error("wheel consumed outside macro mode");

  a_accept_stamps_time: assert property (@(posedge clk) disable iff (!rst_n)
    step && (acc_nxt != acc_r) |=> last_event_r == $past(item.tick_count))
    else $error("button change accepted without stamping the event time");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(acc_r) && $stable(macro_r) && $stable(wheel_right_r) &&
              $stable(last_event_r))
    else $error("state moved without a step");

endmodule

`default_nettype wire

// ===== rtl/mouse_button_qualifier.sv =====
`default_nettype none

// Channel  Dir  Handshake          Payload
// in_ch    in   valid/ready        tick_count, left/right/middle/macro pins, wheel_moved
// out_ch   out  valid/ready        reported_buttons, macro_active, wheel_consumed
// cfg      in   cfg_we (no ready)  cfg_wdata = click_delay_ms
//
// Every poll produces exactly one result. While out_ch.ready is high, the sustained
// rate is one poll per cycle: an input register feeds the lockout compares and the
// state update, whose outcome lands in the result register.
// Reset is synchronous and active low; it clears the macro state, the button
// set, the event time and the pipeline valid bits.
// A stalled output holds its result while the input register can still take
// one more poll; only when both are full is in_ch.ready low.
module mouse_button_qualifier import mbq_pkg::*; #(
  parameter int unsigned CLOCK_HZ = 100000000
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [DELAY_W-1:0] cfg_wdata,
  mbq_in_if.sink                  in_ch,
  mbq_out_if.source               out_ch
);

  // Input register stage.
  logic        s1_valid_r, s1_valid_nxt;
  mbq_item_t   s1_item_r;

  // Result register stage.
  logic        out_valid_r, out_valid_nxt;
  mbq_result_t out_res_r;

  logic        in_fire;
  logic        out_free;
  logic        step;
  logic [TICK_W-1:0] threshold;
  mbq_result_t core_res;

  // The result register is free when it is empty or its transfer completes now.
  // A held poll in the input stage moves forward exactly when that slot is free.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset; the valid bits qualify them.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.tick_count   <= in_ch.tick_count;
      s1_item_r.left_pin_n   <= in_ch.left_pin_n;
      s1_item_r.right_pin_n  <= in_ch.right_pin_n;
      s1_item_r.middle_pin_n <= in_ch.middle_pin_n;
      s1_item_r.macro_pin_n  <= in_ch.macro_pin_n;
      s1_item_r.wheel_moved  <= in_ch.wheel_moved;
    end
    if (step) begin
      out_res_r <= core_res;
    end
  end

  // The hold-off threshold in cycles is recomputed on each delay write.
  mbq_cfg #(
    .CLOCK_HZ (CLOCK_HZ)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .threshold (threshold)
  );

  // Lockouts, macro mode, wheel click mapping and button acceptance.
  mbq_core #(
    .CLOCK_HZ (CLOCK_HZ)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (s1_item_r),
    .threshold (threshold),
    .result    (core_res)
  );

  assign out_ch.valid            = out_valid_r;
  assign out_ch.reported_buttons = out_res_r.reported_buttons;
  assign out_ch.macro_active     = out_res_r.macro_active;
  assign out_ch.wheel_consumed   = out_res_r.wheel_consumed;

endmodule

`default_nettype wire
